### hdl/assert_macros.svh
// Assertion macros for the top-level RTL file, which checks itself.
// Depends on signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds -> c holds in the same cycle
`define ASSERT_IMPLIES(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// a holds -> c holds in the next cycle
`define ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

// a never holds
`define ASSERT_NEVER(lbl, a, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(a)) \
		else $error(msg);

`endif

### hdl/ddko_pkg.sv
// Package for the differential-drive odometry block: widths, codes, constants.
// No dependencies.
`default_nettype none

package ddko_pkg;

	// field widths
	localparam int VEL_W      = 24;
	localparam int DT_W       = 20;
	localparam int RATE_W     = 32;
	localparam int POS_W      = 32;
	localparam int HDG_W      = 32;
	localparam int ANG_W      = 40;
	localparam int RAD_W      = 16;
	localparam int SEP_W      = 20;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION = 4'd1;

	localparam logic [RAD_W-1:0] RAD_RESET = 16'd10813;
	localparam logic [SEP_W-1:0] SEP_RESET = 20'd39322;

	// item kinds
	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// serial multiplier: signed operands, magnitude product
	localparam int MUL_AW = 35;
	localparam int MUL_BW = 33;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// serial divider: dividend magnitude incl. rounding term, divisor
	localparam int DIV_NW = 53;
	localparam int DIV_DW = 20;

	localparam logic [DIV_DW-1:0] USEC_PER_SEC = 20'd1000000;

	// CORDIC
	localparam int CORDIC_ITER_DEF = 16;
	localparam int COR_W           = MUL_BW;
	localparam logic signed [COR_W-1:0]  CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [MUL_BW-1:0] BAM_PER_RAD = 33'sd683565276;

	// arctan(2^-i) as binary angle
	localparam logic [29:0] ATAN_BAM [0:31] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,
		30'd41,        30'd20,        30'd10,        30'd5,
		30'd3,         30'd1,         30'd1,         30'd0
	};

endpackage

`default_nettype wire

### hdl/ddko_ifs.sv
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on ddko_pkg.
`default_nettype none

interface ddko_in_if import ddko_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic signed [VEL_W-1:0] fwd_speed;
	logic signed [VEL_W-1:0] yaw_speed;
	logic [DT_W-1:0]         elapsed_time;

	modport source (output valid, kind, fwd_speed, yaw_speed, elapsed_time,
		input ready);
	modport sink (input valid, kind, fwd_speed, yaw_speed, elapsed_time,
		output ready);
endinterface

interface ddko_out_if import ddko_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] left_wheel_rate;
	logic signed [RATE_W-1:0] right_wheel_rate;
	logic signed [POS_W-1:0]  x_position;
	logic signed [POS_W-1:0]  y_position;
	logic [HDG_W-1:0]         heading;
	logic signed [ANG_W-1:0]  left_wheel_angle;
	logic signed [ANG_W-1:0]  right_wheel_angle;

	modport source (output valid, left_wheel_rate, right_wheel_rate, x_position,
		y_position, heading, left_wheel_angle, right_wheel_angle, input ready);
	modport sink (input valid, left_wheel_rate, right_wheel_rate, x_position,
		y_position, heading, left_wheel_angle, right_wheel_angle, output ready);
endinterface

interface ddko_cfg_if import ddko_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

### hdl/ddko_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ddko_pkg.
`default_nettype none

module ddko_mul import ddko_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [MUL_AW-1:0] a,
	input  logic signed [MUL_BW-1:0] b,
	output logic                     done,
	output logic [MUL_PW-1:0]        p_mag,
	output logic                     p_neg
);

	localparam int CW = $clog2(MUL_BW);

	logic [MUL_AW-1:0] am_q;
	logic [MUL_PW-1:0] p_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;

	logic [MUL_AW-1:0] a_abs;
	logic [MUL_BW-1:0] b_abs;
	logic [MUL_AW:0]   acc;

	assign a_abs = a[MUL_AW-1] ? MUL_AW'(-a) : MUL_AW'(a);
	assign b_abs = b[MUL_BW-1] ? MUL_BW'(-b) : MUL_BW'(b);

	// add the multiplicand into the high half when the low bit is set
	assign acc = {1'b0, p_q[MUL_PW-1:MUL_BW]} + {1'b0, (p_q[0] ? am_q : '0)};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a_abs;
			p_q   <= {{MUL_AW{1'b0}}, b_abs};
			neg_q <= a[MUL_AW-1] ^ b[MUL_BW-1];
		end else if (busy_q) begin
			p_q <= {acc, p_q[MUL_BW-1:1]};
		end
	end

	assign done  = done_q;
	assign p_mag = p_q;
	assign p_neg = neg_q;

endmodule

`default_nettype wire

### hdl/ddko_div.sv
// Bit-serial restoring divider with round-to-nearest, one quotient bit per cycle.
// Depends on ddko_pkg.
`default_nettype none

module ddko_div import ddko_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-2:0] mag,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	localparam int CW = $clog2(DIV_NW);

	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;

	logic [DIV_DW:0] trial;
	logic            ge;

	// shift the next dividend bit into the remainder and try a subtract
	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend gets half the divisor added for rounding
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {1'b0, mag} + DIV_NW'(den >> 1);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

### hdl/ddko_cordic.sv
// Rotation-mode CORDIC on a binary angle, one iteration per cycle.
// Depends on ddko_pkg.
`default_nettype none

module ddko_cordic import ddko_pkg::*; #(
	parameter int ITER = CORDIC_ITER_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [31:0]             phi,
	output logic                    done,
	output logic signed [COR_W-1:0] cos_v,
	output logic signed [COR_W-1:0] sin_v
);

	localparam int CW = $clog2(ITER);

	logic signed [COR_W-1:0] x_q;
	logic signed [COR_W-1:0] y_q;
	logic signed [31:0]      z_q;
	logic [1:0]              quad_q;
	logic                    busy_q;
	logic                    done_q;
	logic [CW-1:0]           cnt_q;

	logic [4:0]              idx;
	logic signed [COR_W-1:0] xs;
	logic signed [COR_W-1:0] ys;
	logic signed [31:0]      atn;

	assign idx = 5'(cnt_q);
	assign xs  = x_q >>> idx;
	assign ys  = y_q >>> idx;
	assign atn = $signed({2'b00, ATAN_BAM[idx]});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// micro-rotations on the angle within the quadrant
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= $signed({2'b00, phi[29:0]});
			quad_q <= phi[31:30];
		end else if (busy_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atn;
			end
		end
	end

	// quadrant fold-out
	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_v = x_q;
				sin_v = y_q;
			end
			2'd1: begin
				cos_v = -y_q;
				sin_v = x_q;
			end
			2'd2: begin
				cos_v = -x_q;
				sin_v = -y_q;
			end
			default: begin
				cos_v = y_q;
				sin_v = -x_q;
			end
		endcase
	end

	assign done = done_q;

endmodule

`default_nettype wire

### hdl/diff_drive_kinematics_odometry_top.sv
// Differential-drive kinematics and odometry, top level with step sequencer.
// Depends on ddko_pkg, ddko_ifs, ddko_mul, ddko_div, ddko_cordic, assert_macros.svh.
//
//  channel   dir  handshake        carries
//  cfg       in   valid/ready      idx, data (wheel radius, wheel separation)
//  in_item   in   valid/ready      kind, linear/angular velocity, elapsed time
//  out_item  out  valid/ready      wheel rates, pose, heading, wheel angles
//
// One item at a time. A command runs one multiply and two divides, a tick seven
// multiplies, three divides and one CORDIC pass, each step on one of the shared
// serial units in turn. Reset clears the state and restores the default geometry.
// A result waiting in the output register does not block the next item; only
// loading a new result waits for the previous one to be taken.
`default_nettype none
`include "assert_macros.svh"

module diff_drive_kinematics_odometry_top import ddko_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ddko_cfg_if.sink   cfg,
	ddko_in_if.sink    in_item,
	ddko_out_if.source out_item
);

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CMD_MUL  = 4'd1;
	localparam logic [3:0] S_CMD_DIVL = 4'd2;
	localparam logic [3:0] S_CMD_DIVR = 4'd3;
	localparam logic [3:0] S_TK_MULL  = 4'd4;
	localparam logic [3:0] S_TK_DIVL  = 4'd5;
	localparam logic [3:0] S_TK_MULR  = 4'd6;
	localparam logic [3:0] S_TK_DIVR  = 4'd7;
	localparam logic [3:0] S_TK_MULS  = 4'd8;
	localparam logic [3:0] S_TK_MULT  = 4'd9;
	localparam logic [3:0] S_TK_DIVT  = 4'd10;
	localparam logic [3:0] S_TK_MULB  = 4'd11;
	localparam logic [3:0] S_TK_COR   = 4'd12;
	localparam logic [3:0] S_TK_MULX  = 4'd13;
	localparam logic [3:0] S_TK_MULY  = 4'd14;
	localparam logic [3:0] S_DONE     = 4'd15;

	localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

	function automatic logic signed [31:0] sat_rate(input logic neg,
		input logic [DIV_NW-1:0] q);
		logic signed [31:0] r;
		if (neg)
			r = (q > DIV_NW'(64'd2147483648)) ? I32_MIN : -$signed(q[31:0]);
		else
			r = (q > DIV_NW'(64'd2147483647)) ? I32_MAX : $signed(q[31:0]);
		return r;
	endfunction

	function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [ANG_W-1:0] a,
		input logic signed [33:0] d);
		logic signed [ANG_W:0] sum;
		sum = (ANG_W+1)'(a) + (ANG_W+1)'(d);
		if (sum[ANG_W] != sum[ANG_W-1])
			return sum[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
		return sum[ANG_W-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647)
			r = I32_MAX;
		else if (v < -36'sd2147483648)
			r = I32_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	// control and state
	logic [3:0]               state_q;
	logic [3:0]               state_nx;
	logic                     go_q;
	logic                     step_done;
	logic                     out_valid_q;
	logic                     in_accept;
	logic                     out_load;
	logic [RAD_W-1:0]         rad_q;
	logic [SEP_W-1:0]         sep_q;
	logic signed [RATE_W-1:0] rate_l_q;
	logic signed [RATE_W-1:0] rate_r_q;
	logic signed [POS_W-1:0]  x_q;
	logic signed [POS_W-1:0]  y_q;
	logic [HDG_W-1:0]         hd_q;
	logic signed [ANG_W-1:0]  ang_l_q;
	logic signed [ANG_W-1:0]  ang_r_q;

	// item and intermediates
	logic signed [VEL_W-1:0]  v_q;
	logic signed [VEL_W-1:0]  w_q;
	logic [DT_W-1:0]          dt_q;
	logic signed [44:0]       wl_q;
	logic signed [33:0]       dl_q;
	logic signed [33:0]       dr_q;
	logic signed [33:0]       s_q;
	logic signed [32:0]       t_q;
	logic [31:0]              b32_q;
	logic [31:0]              phi_q;

	// output register
	logic signed [RATE_W-1:0] o_rl_q;
	logic signed [RATE_W-1:0] o_rr_q;
	logic signed [POS_W-1:0]  o_x_q;
	logic signed [POS_W-1:0]  o_y_q;
	logic [HDG_W-1:0]         o_hd_q;
	logic signed [ANG_W-1:0]  o_al_q;
	logic signed [ANG_W-1:0]  o_ar_q;

	// unit hookup
	logic                     mul_start;
	logic                     mul_done;
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0]        p_mag;
	logic                     p_neg;
	logic                     div_start;
	logic                     div_done;
	logic [DIV_NW-2:0]        div_mag;
	logic [DIV_DW-1:0]        div_den;
	logic [DIV_NW-1:0]        quo;
	logic                     cor_start;
	logic                     cor_done;
	logic signed [COR_W-1:0]  cos_v;
	logic signed [COR_W-1:0]  sin_v;

	// step arithmetic
	logic signed [44:0]       two_v;
	logic signed [44:0]       num_sel;
	logic [44:0]              num_abs;
	logic signed [44:0]       wl_val;
	logic signed [31:0]       rate_val;
	logic signed [33:0]       dq_mag;
	logic signed [33:0]       dq;
	logic signed [34:0]       sum_d;
	logic signed [34:0]       diff_d;
	logic [MUL_PW-1:0]        s_rnd;
	logic [MUL_PW-18:0]       s_m;
	logic [32:0]              s_c;
	logic signed [33:0]       s_val;
	logic [31:0]              t_c;
	logic signed [32:0]       t_val;
	logic signed [32:0]       t_sel;
	logic [MUL_PW-1:0]        b_rnd;
	logic [MUL_PW-17:0]       bm;
	logic [31:0]              b32_val;
	logic [31:0]              h32;
	logic [MUL_PW-1:0]        d_rnd;
	logic [MUL_PW-31:0]       dm;
	logic signed [35:0]       dms;
	logic signed [35:0]       ds;
	logic signed [35:0]       pos_sum;
	logic signed [31:0]       pos_val;

	assign in_accept     = in_item.valid && in_item.ready;
	assign in_item.ready = (state_q == S_IDLE);
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || out_item.ready);
	assign cfg.ready     = 1'b1;

	// command: wheel-rate numerators
	assign two_v   = $signed({{4{v_q[VEL_W-1]}}, v_q, 17'b0});
	assign num_sel = (state_q == S_CMD_DIVL) ? (two_v - wl_q) : (two_v + wl_q);
	assign num_abs = num_sel[44] ? 45'(-num_sel) : 45'(num_sel);
	assign wl_val  = p_neg ? -$signed({1'b0, p_mag[43:0]}) : $signed({1'b0, p_mag[43:0]});

	always_comb begin
		if (rad_q == '0)
			rate_val = (num_sel == '0) ? '0 : (num_sel[44] ? I32_MIN : I32_MAX);
		else
			rate_val = sat_rate(num_sel[44], quo);
	end

	// tick: wheel steps, travel, turn
	assign dq_mag = $signed({1'b0, quo[32:0]});
	assign dq     = p_neg ? -dq_mag : dq_mag;
	assign sum_d  = 35'(dl_q) + 35'(dr_q);
	assign diff_d = 35'(dr_q) - 35'(dl_q);

	assign s_rnd = p_mag + MUL_PW'(65536);
	assign s_m   = s_rnd[MUL_PW-1:17];
	assign s_c   = (s_m > (MUL_PW-17)'(64'h1_0000_0000)) ? 33'h1_0000_0000 : s_m[32:0];
	assign s_val = p_neg ? -$signed({1'b0, s_c}) : $signed({1'b0, s_c});

	assign t_c   = (quo > DIV_NW'(64'h8000_0000)) ? 32'h8000_0000 : quo[31:0];
	assign t_val = p_neg ? -$signed({1'b0, t_c}) : $signed({1'b0, t_c});

	// zero separation: turn pinned to the clamp by sign
	always_comb begin
		if (sep_q != '0)
			t_sel = t_val;
		else if (p_mag == '0)
			t_sel = '0;
		else
			t_sel = p_neg ? $signed(33'h1_8000_0000) : $signed(33'h0_8000_0000);
	end

	// turn as binary angle and half of it
	assign b_rnd   = p_mag + MUL_PW'(32768);
	assign bm      = b_rnd[MUL_PW-1:16];
	assign b32_val = p_neg ? -bm[31:0] : bm[31:0];
	assign h32     = p_neg ? -bm[32:1] : bm[32:1];

	// position step along the midpoint heading
	assign d_rnd   = p_mag + MUL_PW'(64'h2000_0000);
	assign dm      = d_rnd[MUL_PW-1:30];
	assign dms     = $signed({2'b00, dm[33:0]});
	assign ds      = p_neg ? -dms : dms;
	assign pos_sum = 36'((state_q == S_TK_MULX) ? x_q : y_q) + ds;
	assign pos_val = sat32(pos_sum);

	// operand select and unit starts
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_mag   = '0;
		div_den   = USEC_PER_SEC;
		mul_start = 1'b0;
		div_start = 1'b0;
		cor_start = 1'b0;
		step_done = 1'b0;
		state_nx  = state_q;
		case (state_q)
			S_IDLE: begin
				step_done = in_accept;
				state_nx  = (in_item.kind == KIND_TICK) ? S_TK_MULL : S_CMD_MUL;
			end
			S_CMD_MUL: begin
				mul_a     = MUL_AW'(w_q);
				mul_b     = MUL_BW'($signed({1'b0, sep_q}));
				mul_start = go_q;
				step_done = mul_done;
				state_nx  = S_CMD_DIVL;
			end
			S_CMD_DIVL, S_CMD_DIVR: begin
				div_mag   = (DIV_NW-1)'(num_abs);
				div_den   = DIV_DW'({rad_q, 1'b0});
				div_start = go_q && (rad_q != '0);
				step_done = (rad_q == '0) ? go_q : div_done;
				state_nx  = (state_q == S_CMD_DIVL) ? S_CMD_DIVR : S_DONE;
			end
			S_TK_MULL, S_TK_MULR: begin
				mul_a     = MUL_AW'((state_q == S_TK_MULL) ? rate_l_q : rate_r_q);
				mul_b     = MUL_BW'($signed({1'b0, dt_q}));
				mul_start = go_q;
				step_done = mul_done;
				state_nx  = (state_q == S_TK_MULL) ? S_TK_DIVL : S_TK_DIVR;
			end
			S_TK_DIVL, S_TK_DIVR: begin
				div_mag   = p_mag[DIV_NW-2:0];
				div_start = go_q;
				step_done = div_done;
				state_nx  = (state_q == S_TK_DIVL) ? S_TK_MULR : S_TK_MULS;
			end
			S_TK_MULS, S_TK_MULT: begin
				mul_a     = MUL_AW'((state_q == S_TK_MULS) ? sum_d : diff_d);
				mul_b     = MUL_BW'($signed({1'b0, rad_q}));
				mul_start = go_q;
				step_done = mul_done;
				state_nx  = (state_q == S_TK_MULS) ? S_TK_MULT : S_TK_DIVT;
			end
			S_TK_DIVT: begin
				div_mag   = p_mag[DIV_NW-2:0];
				div_den   = sep_q;
				div_start = go_q && (sep_q != '0);
				step_done = (sep_q == '0) ? go_q : div_done;
				state_nx  = S_TK_MULB;
			end
			S_TK_MULB: begin
				mul_a     = MUL_AW'(t_q);
				mul_b     = BAM_PER_RAD;
				mul_start = go_q;
				step_done = mul_done;
				state_nx  = S_TK_COR;
			end
			S_TK_COR: begin
				cor_start = go_q;
				step_done = cor_done;
				state_nx  = S_TK_MULX;
			end
			S_TK_MULX, S_TK_MULY: begin
				mul_a     = MUL_AW'(s_q);
				mul_b     = (state_q == S_TK_MULX) ? cos_v : sin_v;
				mul_start = go_q;
				step_done = mul_done;
				state_nx  = (state_q == S_TK_MULX) ? S_TK_MULY : S_DONE;
			end
			S_DONE: begin
				step_done = out_load;
				state_nx  = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// sequencer, geometry and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			go_q     <= 1'b0;
			rad_q    <= RAD_RESET;
			sep_q    <= SEP_RESET;
			rate_l_q <= '0;
			rate_r_q <= '0;
			x_q      <= '0;
			y_q      <= '0;
			hd_q     <= '0;
			ang_l_q  <= '0;
			ang_r_q  <= '0;
		end else begin
			go_q <= step_done && (state_q != S_DONE);
			if (step_done)
				state_q <= state_nx;
			if (cfg.valid) begin
				case (cfg.idx)
					CFG_RADIUS:     rad_q <= cfg.data[RAD_W-1:0];
					CFG_SEPARATION: sep_q <= cfg.data[SEP_W-1:0];
					default: ;
				endcase
			end
			if (step_done) begin
				case (state_q)
					S_CMD_DIVL: rate_l_q <= rate_val;
					S_CMD_DIVR: rate_r_q <= rate_val;
					S_TK_DIVL:  ang_l_q  <= sat_ang(ang_l_q, dq);
					S_TK_DIVR:  ang_r_q  <= sat_ang(ang_r_q, dq);
					S_TK_MULX:  x_q      <= pos_val;
					S_TK_MULY: begin
						y_q  <= pos_val;
						hd_q <= hd_q + b32_q;
					end
					default: ;
				endcase
			end
		end
	end

	// item capture and step results
	always_ff @(posedge clk) begin
		if (step_done) begin
			case (state_q)
				S_IDLE: begin
					v_q  <= in_item.fwd_speed;
					w_q  <= in_item.yaw_speed;
					dt_q <= in_item.elapsed_time;
				end
				S_CMD_MUL: wl_q <= wl_val;
				S_TK_DIVL: dl_q <= dq;
				S_TK_DIVR: dr_q <= dq;
				S_TK_MULS: s_q  <= s_val;
				S_TK_DIVT: t_q  <= t_sel;
				S_TK_MULB: begin
					b32_q <= b32_val;
					phi_q <= hd_q + h32;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_rl_q <= rate_l_q;
			o_rr_q <= rate_r_q;
			o_x_q  <= x_q;
			o_y_q  <= y_q;
			o_hd_q <= hd_q;
			o_al_q <= ang_l_q;
			o_ar_q <= ang_r_q;
		end
	end

	assign out_item.valid             = out_valid_q;
	assign out_item.left_wheel_rate   = o_rl_q;
	assign out_item.right_wheel_rate  = o_rr_q;
	assign out_item.x_position        = o_x_q;
	assign out_item.y_position        = o_y_q;
	assign out_item.heading           = o_hd_q;
	assign out_item.left_wheel_angle  = o_al_q;
	assign out_item.right_wheel_angle = o_ar_q;

	// shared arithmetic units
	ddko_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p_mag  (p_mag),
		.p_neg  (p_neg)
	);

	ddko_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (div_mag),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	ddko_cordic #(
		.ITER (CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.phi    (phi_q),
		.done   (cor_done),
		.cos_v  (cos_v),
		.sin_v  (sin_v)
	);

	// checks
	`ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_q != S_IDLE, "item accepted but sequencer idle")
	`ASSERT_IMPLIES(a_result_from_done, $rose(out_valid_q), $past(state_q) == S_DONE, "result without finished item")
	`ASSERT_NEVER(a_one_unit_started, (mul_start && div_start) || (mul_start && cor_start) || (div_start && cor_start), "two units started together")

endmodule

`default_nettype wire
